@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/rise_pkg.sv @@
`default_nettype none
package rise_pkg;

   typedef enum logic [1:0] {
      MODE_ADD   = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_REWIND = 2'd2,
      MODE_NEXT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_RANGE = 2'd1,
      ST_FULL      = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [63:0] first_row;
      logic [15:0]        range_count;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic signed [63:0] row_out;
      logic               row_valid;
      logic [10:0]        set_count;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ADD_NEXT,
      S_LOOK_INIT,
      S_LOOK_RD,
      S_LOOK_CMP,
      S_ADD_WR,
      S_Q_DONE,
      S_SORT_I,
      S_SORT_RDV,
      S_SORT_RDJ,
      S_SORT_CMP,
      S_SORT_MOVE,
      S_RD_ROW,
      S_RD_WAIT,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

@@ rtl/row_id_set_engine_top.sv @@
// Query: binary search over the store when sorted, linear scan when unsorted.
// Add range: per id one membership lookup plus a write if the id is absent; sort is
// insertion sort. Single-port store read: one read per cycle bounds all.
// Throughput: one command at a time; busy stays high through the rsp_valid strobe cycle.
// Reset: synchronous, clears count, cursor and sets the sorted flag; store is not cleared.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
`default_nettype none
module row_id_set_engine_top
   import rise_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  wire  logic    clock,
   input  wire  logic    reset,
   input  wire  logic    start,
   output logic          busy,
   input  wire  req_type req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);
`include "assert_macros.svh"

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [63:0] mem [CAPACITY];
   logic [63:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [63:0]   wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CW-1:0] count_ff, count_in, cursor_ff, cursor_in;
   logic          sorted_ff, sorted_in;
   logic [63:0]   id_ff, id_in;
   logic [15:0]   left_ff, left_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [63:0]   v_ff, v_in;
   logic          lookup_sort_ff, lookup_sort_in; // lookup is for add
   logic [1:0]    status_ff, status_in;
   logic          found_ff, found_in;
   logic [63:0]   row_ff, row_in;
   logic          valid_ff, valid_in;
   logic          hold_ff, hold_in;

   logic [CW-1:0] mid_calc;
   logic          lt_id, eq_id, v_lt;
   logic [63:0]   range_sum;

   always_comb begin
      lt_id = $signed(id_ff) < $signed(rd_ff);
      eq_id = rd_ff == id_ff;
      v_lt  = $signed(v_ff) < $signed(rd_ff);
      mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
      range_sum = req_data.first_row + {48'd0, req_data.range_count};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
         sorted_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         sorted_ff <= sorted_in;
      end
      req_ff <= (state_ff == S_IDLE) ? req_data : req_ff;
      id_ff <= id_in;   left_ff <= left_in;
      lo_ff <= lo_in;   hi_ff <= hi_in;   mid_ff <= mid_in;
      i_ff <= i_in;     j_ff <= j_in;     v_ff <= v_in;
      lookup_sort_ff <= lookup_sort_in;
      status_ff <= status_in; found_ff <= found_in;
      row_ff <= row_in; valid_ff <= valid_in; hold_ff <= hold_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;  cursor_in = cursor_ff;  sorted_in = sorted_ff;
      id_in = id_ff;  left_in = left_ff;  lo_in = lo_ff;  hi_in = hi_ff;
      mid_in = mid_ff;  i_in = i_ff;  j_in = j_ff;  v_in = v_ff;
      lookup_sort_in = lookup_sort_ff;
      status_in = status_ff;  found_in = found_ff;
      row_in = row_ff;  valid_in = valid_ff;  hold_in = hold_ff;
      rd_addr = '0;  wr_en = 1'b0;  wr_addr = '0;  wr_data = '0;
      busy = 1'b1;  rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               status_in = ST_OK;  found_in = 1'b0;
               row_in = '0;  valid_in = 1'b0;
               id_in = req_data.first_row;
               left_in = req_data.range_count;
               unique case (mode_type'(req_data.mode))
                  MODE_ADD: begin
                     lookup_sort_in = 1'b1;
                     // a negative start can never run past the largest id
                     if (!req_data.first_row[63] && range_sum[63]) begin
                        status_in = ST_BAD_RANGE;
                        state_in = S_RESP;
                     end else state_in = S_ADD_NEXT;
                  end
                  MODE_QUERY: begin
                     lookup_sort_in = 1'b0;
                     state_in = S_LOOK_INIT;
                  end
                  MODE_REWIND: begin
                     cursor_in = '0;
                     if (sorted_ff || count_ff <= CW'(1)) state_in = S_RD_ROW;
                     else begin
                        i_in = CW'(1);
                        state_in = S_SORT_I;
                     end
                  end
                  MODE_NEXT: begin
                     if (cursor_ff >= count_ff) begin
                        status_in = ST_EXHAUSTED;
                        state_in = S_RESP;
                     end else begin
                        cursor_in = cursor_ff + CW'(1);
                        state_in = S_RD_ROW;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_ADD_NEXT: begin
            if (left_ff == '0) state_in = S_RESP;
            else state_in = S_LOOK_INIT;
         end
         S_LOOK_INIT: begin
            lo_in = '0;  hi_in = count_ff;
            state_in = S_LOOK_RD;
         end
         S_LOOK_RD: begin
            if (lo_ff >= hi_ff) begin
               found_in = 1'b0;
               state_in = lookup_sort_ff ? S_ADD_WR : S_Q_DONE;
            end else begin
               mid_in = sorted_ff ? mid_calc : lo_ff;
               rd_addr = AW'(sorted_ff ? mid_calc : lo_ff);
               state_in = S_LOOK_CMP;
            end
         end
         S_LOOK_CMP: begin
            if (eq_id) begin
               found_in = 1'b1;
               state_in = lookup_sort_ff ? S_ADD_WR : S_Q_DONE;
            end else begin
               if (sorted_ff && lt_id) hi_in = mid_ff;
               else lo_in = mid_ff + CW'(1);
               state_in = S_LOOK_RD;
            end
         end
         S_Q_DONE: state_in = S_RESP;
         S_ADD_WR: begin
            if (found_ff) begin
               id_in = id_ff + 64'd1;  left_in = left_ff - 16'd1;
               found_in = 1'b0;
               state_in = S_ADD_NEXT;
            end else if (count_ff >= CW'(CAPACITY)) begin
               status_in = ST_FULL;
               state_in = S_RESP;
            end else if (!hold_ff && count_ff != '0 && sorted_ff) begin
               // fetch last held id before appending
               rd_addr = AW'(count_ff - CW'(1));
               hold_in = 1'b1;
            end else begin
               hold_in = 1'b0;
               if (sorted_ff && count_ff != '0 && $signed(id_ff) < $signed(rd_ff))
                  sorted_in = 1'b0;
               wr_en = 1'b1;  wr_addr = AW'(count_ff);  wr_data = id_ff;
               count_in = count_ff + CW'(1);
               id_in = id_ff + 64'd1;  left_in = left_ff - 16'd1;
               state_in = S_ADD_NEXT;
            end
         end
         S_SORT_I: begin
            if (i_ff >= count_ff) begin
               sorted_in = 1'b1;
               state_in = S_RD_ROW;
            end else begin
               rd_addr = AW'(i_ff);
               j_in = i_ff;
               state_in = S_SORT_RDV;
            end
         end
         S_SORT_RDV: begin
            v_in = rd_ff;
            state_in = S_SORT_RDJ;
         end
         S_SORT_RDJ: begin
            if (j_ff == '0) begin
               wr_en = 1'b1;  wr_addr = AW'(j_ff);  wr_data = v_ff;
               i_in = i_ff + CW'(1);
               state_in = S_SORT_I;
            end else begin
               rd_addr = AW'(j_ff - CW'(1));
               state_in = S_SORT_CMP;
            end
         end
         S_SORT_CMP: begin
            wr_en = 1'b1;  wr_addr = AW'(j_ff);
            if (v_lt) begin
               wr_data = rd_ff;
               j_in = j_ff - CW'(1);
               state_in = S_SORT_RDJ;
            end else begin
               wr_data = v_ff;
               i_in = i_ff + CW'(1);
               state_in = S_SORT_I;
            end
         end
         S_RD_ROW: begin
            rd_addr = AW'(cursor_ff);
            state_in = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            if (cursor_ff < count_ff) begin
               row_in = rd_ff;  valid_in = 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_data.status    = status_ff;
      rsp_data.found     = found_ff & ~lookup_sort_ff & (req_ff.mode == MODE_QUERY);
      rsp_data.row_out   = row_ff;
      rsp_data.row_valid = valid_ff;
      rsp_data.set_count = 11'(count_ff);
   end

   `ASSERT_IMPL(a_cnt_cap, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `ASSERT_NEXT(a_rsp_idle, clock, reset, rsp_valid, state_ff == S_IDLE)
   `ASSERT_IMPL(a_cursor, clock, reset, state_ff == S_IDLE, cursor_ff <= count_ff)

endmodule
`default_nettype wire
